// ===== rtl/lphtbl_pkg.sv =====
// ----------------------------------------------------------------------------
// lphtbl_pkg
// Shared types and constants for the linear probing hash table core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lphtbl_pkg;

  localparam int KEY_W           = 16;
  localparam int POS_W           = 16;
  localparam int SLOT_OUT_W      = 4;
  localparam int TABLE_SLOTS_DEF = 16;

  localparam logic [POS_W-1:0] POS_MAX = '1;

  localparam logic [1:0] ACT_INSERT  = 2'd0;
  localparam logic [1:0] ACT_REPLACE = 2'd1;
  localparam logic [1:0] ACT_LOOKUP  = 2'd2;
  // spare code, decoded as a lookup
  localparam logic [1:0] ACT_SPARE   = 2'd3;

  localparam logic [1:0] STAT_INSERTED = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_FOUND    = 2'd2;
  localparam logic [1:0] STAT_MISSING  = 2'd3;

  typedef struct packed {
    logic [1:0]       action;
    logic [KEY_W-1:0] key;
  } in_word_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [SLOT_OUT_W-1:0] slot;
    logic [POS_W-1:0]      position;
    logic                  moved;
  } out_word_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [POS_W-1:0] pos;
  } entry_t;

endpackage

`default_nettype wire

// ===== rtl/lphtbl_mod.sv =====
// ----------------------------------------------------------------------------
// lphtbl_mod
// Key modulo slot count. A mask for a power-of-two slot count, otherwise a
// reciprocal multiply followed by a back-multiply, each registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lphtbl_mod #(
  parameter int TABLE_SLOTS = lphtbl_pkg::TABLE_SLOTS_DEF,
  parameter int SLOT_W      = $clog2(TABLE_SLOTS)
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           go,
  input  wire [lphtbl_pkg::KEY_W-1:0]   num,
  output logic                          done,
  output logic [SLOT_W-1:0]             rem
);

  localparam int KEY_W = lphtbl_pkg::KEY_W;

  generate
    if ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0) begin : g_mask
      logic              done_r;
      logic [SLOT_W-1:0] rem_r;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          done_r <= 1'b0;
        end else begin
          done_r <= go;
        end
      end

      always_ff @(posedge clk) begin
        if (go) begin
          rem_r <= num[SLOT_W-1:0];
        end
      end

      assign done = done_r;
      assign rem  = rem_r;
    end else begin : g_recip
      // quotient = (num * ceil(2^SHIFT / slots)) >> SHIFT, exact for any
      // KEY_W-bit num; only the low bits of quotient * slots are needed
      localparam int SHIFT   = KEY_W + SLOT_W;
      localparam int RECIP_W = KEY_W + 1;
      localparam int PROD_W  = KEY_W + RECIP_W;
      localparam longint RECIP_L =
        ((longint'(1) << SHIFT) + longint'(TABLE_SLOTS) - longint'(1)) /
        longint'(TABLE_SLOTS);
      localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'(RECIP_L);
      localparam logic [SLOT_W-1:0]  DIVISOR = SLOT_W'(TABLE_SLOTS);

      logic                stg_r;
      logic                done_r;
      logic [KEY_W-1:0]    num_r;
      logic [PROD_W-1:0]   prod_r;
      logic [SLOT_W-1:0]   rem_r;
      logic [KEY_W-1:0]    quo;
      logic [2*SLOT_W-1:0] qn;

      assign quo = KEY_W'(prod_r >> SHIFT);
      assign qn  = {{SLOT_W{1'b0}}, quo[SLOT_W-1:0]} * {{SLOT_W{1'b0}}, DIVISOR};

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          stg_r  <= 1'b0;
          done_r <= 1'b0;
        end else begin
          stg_r  <= go;
          done_r <= stg_r;
        end
      end

      always_ff @(posedge clk) begin
        if (go) begin
          num_r  <= num;
          prod_r <= {{RECIP_W{1'b0}}, num} * {{KEY_W{1'b0}}, RECIP};
        end
        if (stg_r) begin
          rem_r <= num_r[SLOT_W-1:0] - qn[SLOT_W-1:0];
        end
      end

      assign done = done_r;
      assign rem  = rem_r;
    end
  endgenerate

endmodule

`default_nettype wire

// ===== rtl/lphtbl_ram.sv =====
// ----------------------------------------------------------------------------
// lphtbl_ram
// Slot store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lphtbl_ram #(
  parameter int TABLE_SLOTS = lphtbl_pkg::TABLE_SLOTS_DEF,
  parameter int SLOT_W      = $clog2(TABLE_SLOTS)
) (
  input  wire                         clk,
  input  wire                         wr_en,
  input  wire [SLOT_W-1:0]            wr_addr,
  input  wire lphtbl_pkg::entry_t     wr_data,
  input  wire [SLOT_W-1:0]            rd_addr,
  output lphtbl_pkg::entry_t          rd_data
);

  lphtbl_pkg::entry_t mem_r [TABLE_SLOTS];
  lphtbl_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== rtl/linear_probe_hash_table_core.sv =====
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core
// Open-addressed hash table, linear probing, optional displacement insert.
// ----------------------------------------------------------------------------
// Flow: key remainder, home slot read and check, then a walk of the table (one
//   slot per cycle through the RAM read port) when the home slot does not
//   settle it; a displacement insert first takes the occupant's remainder. A
//   non-power-of-two slot count uses the reciprocal remainder. One word in
//   flight; busy covers it. Reset: a clearing pass empties the RAM, busy high.
// Results are strobed by out_valid for one cycle; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module linear_probe_hash_table_core #(
  parameter int TABLE_SLOTS = lphtbl_pkg::TABLE_SLOTS_DEF
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     start,
  output logic                    busy,
  input  wire lphtbl_pkg::in_word_t in_word,
  output logic                    out_valid,
  output lphtbl_pkg::out_word_t   out_word
);

  localparam int SLOT_W     = $clog2(TABLE_SLOTS);
  localparam int KEY_W      = lphtbl_pkg::KEY_W;
  localparam int POS_W      = lphtbl_pkg::POS_W;
  localparam int SLOT_OUT_W = lphtbl_pkg::SLOT_OUT_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_HOME  = 7'b0000100,
    ST_RDH   = 7'b0001000,
    ST_CHKH  = 7'b0010000,
    ST_OWN   = 7'b0100000,
    ST_SCAN  = 7'b1000000
  } state_t;

  state_t                state_r, state_nxt;
  logic [SLOT_W-1:0]     clr_addr_r, clr_addr_nxt;
  logic [1:0]            action_r, action_nxt;
  logic [KEY_W-1:0]      key_r, key_nxt;
  logic [SLOT_W-1:0]     home_r, home_nxt;
  logic [POS_W-1:0]      next_pos_r, next_pos_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [KEY_W-1:0]      carry_key_r, carry_key_nxt;
  logic [POS_W-1:0]      carry_pos_r, carry_pos_nxt;
  logic                  evict_r, evict_nxt;
  logic [SLOT_W-1:0]     scan_addr_r, scan_addr_nxt;
  logic [SLOT_W-1:0]     chk_addr_r, chk_addr_nxt;
  logic [SLOT_W-1:0]     issue_left_r, issue_left_nxt;
  logic [SLOT_W-1:0]     chk_left_r, chk_left_nxt;
  logic                  pend_r, pend_nxt;
  logic                  out_valid_r, out_valid_nxt;
  lphtbl_pkg::out_word_t out_word_r, out_word_nxt;

  logic                  mem_we;
  logic [SLOT_W-1:0]     mem_waddr;
  lphtbl_pkg::entry_t    mem_wdata;
  logic [SLOT_W-1:0]     mem_raddr;
  lphtbl_pkg::entry_t    rd;

  logic                  mod_go;
  logic [KEY_W-1:0]      mod_num;
  logic                  mod_done;
  logic [SLOT_W-1:0]     mod_rem;

  logic                  take_pos;
  logic                  is_insert, is_replace, is_lookup;
  logic                  hit;
  logic [SLOT_W-1:0]     home_after;
  logic [SLOT_W-1:0]     scan_after;

  lphtbl_mod #(.TABLE_SLOTS(TABLE_SLOTS), .SLOT_W(SLOT_W)) u_mod (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (mod_go),
    .num  (mod_num),
    .done (mod_done),
    .rem  (mod_rem)
  );

  lphtbl_ram #(.TABLE_SLOTS(TABLE_SLOTS), .SLOT_W(SLOT_W)) u_ram (
    .clk    (clk),
    .wr_en  (mem_we),
    .wr_addr(mem_waddr),
    .wr_data(mem_wdata),
    .rd_addr(mem_raddr),
    .rd_data(rd)
  );

  assign is_insert  = (action_r == lphtbl_pkg::ACT_INSERT);
  assign is_replace = (action_r == lphtbl_pkg::ACT_REPLACE);
  assign is_lookup  = !is_insert && !is_replace;
  assign home_after = (home_r == LAST_SLOT) ? '0 : home_r + SLOT_W'(1);
  assign scan_after = (scan_addr_r == LAST_SLOT) ? '0 : scan_addr_r + SLOT_W'(1);
  assign hit        = is_lookup ? (rd.valid && rd.key == key_r) : !rd.valid;

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    action_nxt     = action_r;
    key_nxt        = key_r;
    home_nxt       = home_r;
    pos_nxt        = pos_r;
    carry_key_nxt  = carry_key_r;
    carry_pos_nxt  = carry_pos_r;
    evict_nxt      = evict_r;
    scan_addr_nxt  = scan_addr_r;
    chk_addr_nxt   = chk_addr_r;
    issue_left_nxt = issue_left_r;
    chk_left_nxt   = chk_left_r;
    pend_nxt       = 1'b0;
    out_valid_nxt  = 1'b0;
    out_word_nxt   = out_word_r;
    take_pos       = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = home_r;
    mem_wdata      = '{valid: 1'b1, key: key_r, pos: next_pos_r};
    mem_raddr      = home_r;
    mod_go         = 1'b0;
    mod_num        = in_word.key;

    unique case (state_r)
      ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        mem_wdata    = '0;
        clr_addr_nxt = clr_addr_r + SLOT_W'(1);
        if (clr_addr_r == LAST_SLOT) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          action_nxt = in_word.action;
          key_nxt    = in_word.key;
          mod_go     = 1'b1;
          state_nxt  = ST_HOME;
        end
      end
      ST_HOME: begin
        if (mod_done) begin
          home_nxt  = mod_rem;
          state_nxt = ST_RDH;
        end
      end
      ST_RDH: begin
        state_nxt = ST_CHKH;
      end
      ST_CHKH: begin
        // home slot entry is on rd this cycle
        scan_addr_nxt  = home_after;
        issue_left_nxt = LAST_SLOT;
        chk_left_nxt   = LAST_SLOT;
        if (is_lookup) begin
          if (hit) begin
            out_valid_nxt = 1'b1;
            out_word_nxt  = '{status: lphtbl_pkg::STAT_FOUND,
                              slot: SLOT_OUT_W'(home_r), position: rd.pos, moved: 1'b0};
            state_nxt     = ST_IDLE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end else if (is_insert) begin
          if (!rd.valid) begin
            mem_we        = 1'b1;
            take_pos      = 1'b1;
            out_valid_nxt = 1'b1;
            out_word_nxt  = '{status: lphtbl_pkg::STAT_INSERTED,
                              slot: SLOT_OUT_W'(home_r), position: next_pos_r, moved: 1'b0};
            state_nxt     = ST_IDLE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end else begin
          take_pos = 1'b1;
          pos_nxt  = next_pos_r;
          if (!rd.valid) begin
            mem_we        = 1'b1;
            out_valid_nxt = 1'b1;
            out_word_nxt  = '{status: lphtbl_pkg::STAT_INSERTED,
                              slot: SLOT_OUT_W'(home_r), position: next_pos_r, moved: 1'b0};
            state_nxt     = ST_IDLE;
          end else begin
            carry_key_nxt = rd.key;
            carry_pos_nxt = rd.pos;
            mod_go        = 1'b1;
            mod_num       = rd.key;
            state_nxt     = ST_OWN;
          end
        end
      end
      ST_OWN: begin
        if (mod_done) begin
          // occupant away from its own home gets displaced
          evict_nxt = (mod_rem != home_r);
          if (mod_rem != home_r) begin
            mem_we    = 1'b1;
            mem_wdata = '{valid: 1'b1, key: key_r, pos: pos_r};
          end else begin
            carry_key_nxt = key_r;
            carry_pos_nxt = pos_r;
          end
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // reads issue one slot ahead of the check
        mem_raddr    = scan_addr_r;
        chk_addr_nxt = scan_addr_r;
        pend_nxt     = (issue_left_r != '0);
        if (issue_left_r != '0) begin
          scan_addr_nxt  = scan_after;
          issue_left_nxt = issue_left_r - SLOT_W'(1);
        end
        if (pend_r) begin
          if (hit) begin
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
            mem_waddr     = chk_addr_r;
            if (is_lookup) begin
              out_word_nxt = '{status: lphtbl_pkg::STAT_FOUND,
                               slot: SLOT_OUT_W'(chk_addr_r), position: rd.pos, moved: 1'b0};
            end else if (is_insert) begin
              mem_we       = 1'b1;
              take_pos     = 1'b1;
              out_word_nxt = '{status: lphtbl_pkg::STAT_INSERTED,
                               slot: SLOT_OUT_W'(chk_addr_r), position: next_pos_r,
                               moved: 1'b0};
            end else begin
              mem_we       = 1'b1;
              mem_wdata    = '{valid: 1'b1, key: carry_key_r, pos: carry_pos_r};
              out_word_nxt = '{status: lphtbl_pkg::STAT_INSERTED,
                               slot: evict_r ? SLOT_OUT_W'(home_r) : SLOT_OUT_W'(chk_addr_r),
                               position: pos_r, moved: evict_r};
            end
          end else if (chk_left_r == SLOT_W'(1)) begin
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
            if (is_lookup) begin
              out_word_nxt = '{status: lphtbl_pkg::STAT_MISSING,
                               slot: '0, position: '0, moved: 1'b0};
            end else if (is_insert) begin
              out_word_nxt = '{status: lphtbl_pkg::STAT_FULL,
                               slot: '0, position: '0, moved: 1'b0};
            end else begin
              out_word_nxt = '{status: lphtbl_pkg::STAT_FULL,
                               slot: evict_r ? SLOT_OUT_W'(home_r) : '0,
                               position: pos_r, moved: 1'b0};
            end
          end else begin
            chk_left_nxt = chk_left_r - SLOT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    next_pos_nxt = next_pos_r;
    if (take_pos && next_pos_r != lphtbl_pkg::POS_MAX) begin
      next_pos_nxt = next_pos_r + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      next_pos_r  <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      next_pos_r  <= next_pos_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    action_r     <= action_nxt;
    key_r        <= key_nxt;
    home_r       <= home_nxt;
    pos_r        <= pos_nxt;
    carry_key_r  <= carry_key_nxt;
    carry_pos_r  <= carry_pos_nxt;
    evict_r      <= evict_nxt;
    scan_addr_r  <= scan_addr_nxt;
    chk_addr_r   <= chk_addr_nxt;
    issue_left_r <= issue_left_nxt;
    chk_left_r   <= chk_left_nxt;
    out_word_r   <= out_word_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobed while sequencer still busy");

  a_pos_saturate: assert property (@(posedge clk) disable iff (!rst_n)
    (next_pos_r == lphtbl_pkg::POS_MAX) |=> (next_pos_r == lphtbl_pkg::POS_MAX))
    else $error("position counter wrapped");

  a_clear_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> (mem_we && !mem_wdata.valid))
    else $error("clearing pass failed to empty a slot");

endmodule

`default_nettype wire
